FILE: rtl/core/ctt_pkg.sv
package ctt_pkg;

    localparam int MaxEvents = 4;
    localparam int CountWidth = $clog2(MaxEvents + 1);
    localparam int PtrWidth = $clog2(MaxEvents);

    localparam logic [2:0] EV_BEGIN   = 3'd0;
    localparam logic [2:0] EV_CONTENT = 3'd1;
    localparam logic [2:0] EV_END     = 3'd2;
    localparam logic [2:0] EV_ABANDON = 3'd3;
    localparam logic [2:0] EV_EOF     = 3'd4;

    localparam logic [3:0] TK_LPAREN  = 4'd0;
    localparam logic [3:0] TK_RPAREN  = 4'd1;
    localparam logic [3:0] TK_LBRACE  = 4'd2;
    localparam logic [3:0] TK_RBRACE  = 4'd3;
    localparam logic [3:0] TK_LBRACK  = 4'd4;
    localparam logic [3:0] TK_RBRACK  = 4'd5;
    localparam logic [3:0] TK_HYPHEN  = 4'd6;
    localparam logic [3:0] TK_COMMA   = 4'd7;
    localparam logic [3:0] TK_STRING  = 4'd8;
    localparam logic [3:0] TK_IDENT   = 4'd9;
    localparam logic [3:0] TK_EOF     = 4'd10;

    localparam logic [7:0] CH_NUL     = 8'h00;
    localparam logic [7:0] CH_NEWLINE = 8'h0A;
    localparam logic [7:0] CH_QUOTE   = 8'h22;
    localparam logic [7:0] CH_LPAREN  = 8'h28;
    localparam logic [7:0] CH_RPAREN  = 8'h29;
    localparam logic [7:0] CH_COMMA   = 8'h2C;
    localparam logic [7:0] CH_HYPHEN  = 8'h2D;
    localparam logic [7:0] CH_SLASH   = 8'h2F;
    localparam logic [7:0] CH_UPPER_A = 8'h41;
    localparam logic [7:0] CH_UPPER_Z = 8'h5A;
    localparam logic [7:0] CH_LBRACK  = 8'h5B;
    localparam logic [7:0] CH_BSLASH  = 8'h5C;
    localparam logic [7:0] CH_RBRACK  = 8'h5D;
    localparam logic [7:0] CH_LOWER_A = 8'h61;
    localparam logic [7:0] CH_LOWER_Z = 8'h7A;
    localparam logic [7:0] CH_LBRACE  = 8'h7B;
    localparam logic [7:0] CH_RBRACE  = 8'h7D;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       is_last;
    } ctt_in_t;

    typedef struct packed {
        logic [2:0] event_kind;
        logic [3:0] token_kind;
        logic [7:0] char_out;
        logic       last_of_run;
    } ctt_out_t;

    typedef struct packed {
        ctt_out_t [MaxEvents-1:0] ev;
        logic [CountWidth-1:0]    count;
    } ctt_batch_t;

endpackage

FILE: rtl/core/ctt_scan.sv
module ctt_scan (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                accept,
    input  ctt_pkg::ctt_in_t    item,
    output ctt_pkg::ctt_batch_t batch
);
    import ctt_pkg::*;

    typedef enum logic [2:0] {
        MODE_SKIP    = 3'd0,
        MODE_SLASH   = 3'd1,
        MODE_COMMENT = 3'd2,
        MODE_IDENT   = 3'd3,
        MODE_STRING  = 3'd4,
        MODE_ESCAPE  = 3'd5
    } mode_t;

    mode_t mode_reg;
    mode_t mode_next;
    mode_t fresh_mode;
    ctt_batch_t fresh_batch;

    function automatic ctt_batch_t push(ctt_batch_t b, logic [2:0] ek, logic [3:0] tk,
                                        logic [7:0] ch);
        ctt_batch_t r;
        r = b;
        if (r.count < CountWidth'(MaxEvents))
        begin
            r.ev[r.count[PtrWidth-1:0]].event_kind  = ek;
            r.ev[r.count[PtrWidth-1:0]].token_kind  = tk;
            r.ev[r.count[PtrWidth-1:0]].char_out    = ch;
            r.ev[r.count[PtrWidth-1:0]].last_of_run = 1'b0;
            r.count = r.count + CountWidth'(1);
        end
        return r;
    endfunction

    function automatic logic is_alpha(logic [7:0] b);
        return (b inside {[CH_UPPER_A:CH_UPPER_Z]}) || (b inside {[CH_LOWER_A:CH_LOWER_Z]});
    endfunction

    // single-character token lookup; valid flag in the top bit
    function automatic logic [4:0] single_kind(logic [7:0] b);
        case (b)
            CH_LPAREN: return {1'b1, TK_LPAREN};
            CH_RPAREN: return {1'b1, TK_RPAREN};
            CH_LBRACE: return {1'b1, TK_LBRACE};
            CH_RBRACE: return {1'b1, TK_RBRACE};
            CH_LBRACK: return {1'b1, TK_LBRACK};
            CH_RBRACK: return {1'b1, TK_RBRACK};
            CH_HYPHEN: return {1'b1, TK_HYPHEN};
            CH_COMMA:  return {1'b1, TK_COMMA};
            default:   return {1'b0, TK_LPAREN};
        endcase
    endfunction

    function automatic ctt_batch_t scan_fresh(ctt_batch_t b, logic [7:0] ch);
        ctt_batch_t r;
        logic [4:0] sk;
        r = b;
        sk = single_kind(ch);
        if (is_alpha(ch))
        begin
            r = push(r, EV_BEGIN, TK_IDENT, CH_NUL);
            r = push(r, EV_CONTENT, TK_IDENT, ch);
        end
        else if (ch == CH_QUOTE)
        begin
            r = push(r, EV_BEGIN, TK_STRING, CH_NUL);
        end
        else if (sk[4])
        begin
            r = push(r, EV_BEGIN, sk[3:0], CH_NUL);
            r = push(r, EV_END, sk[3:0], CH_NUL);
        end
        return r;
    endfunction

    always_comb
    begin
        if (is_alpha(item.data_byte))
            fresh_mode = MODE_IDENT;
        else if (item.data_byte == CH_QUOTE)
            fresh_mode = MODE_STRING;
        else if (item.data_byte == CH_SLASH)
            fresh_mode = MODE_SLASH;
        else
            fresh_mode = MODE_SKIP;
    end

    always_comb
    begin
        ctt_batch_t b;
        mode_t m;
        logic [CountWidth-1:0] last_idx;
        b = '0;
        m = mode_reg;
        if (item.data_byte != CH_NUL)
        begin
            case (mode_reg)
                MODE_SLASH:
                begin
                    if (item.data_byte == CH_SLASH)
                        m = MODE_COMMENT;
                    else
                    begin
                        b = scan_fresh(b, item.data_byte);
                        m = fresh_mode;
                    end
                end
                MODE_COMMENT:
                begin
                    if (item.data_byte == CH_NEWLINE)
                        m = MODE_SKIP;
                end
                MODE_IDENT:
                begin
                    if (is_alpha(item.data_byte))
                        b = push(b, EV_CONTENT, TK_IDENT, item.data_byte);
                    else
                    begin
                        b = push(b, EV_END, TK_IDENT, CH_NUL);
                        b = scan_fresh(b, item.data_byte);
                        m = fresh_mode;
                    end
                end
                MODE_STRING:
                begin
                    if (item.data_byte == CH_BSLASH)
                        m = MODE_ESCAPE;
                    else if (item.data_byte == CH_QUOTE)
                    begin
                        b = push(b, EV_END, TK_STRING, CH_NUL);
                        m = MODE_SKIP;
                    end
                    else
                        b = push(b, EV_CONTENT, TK_STRING, item.data_byte);
                end
                MODE_ESCAPE:
                begin
                    b = push(b, EV_CONTENT, TK_STRING, item.data_byte);
                    m = MODE_STRING;
                end
                default:
                begin
                    b = scan_fresh(b, item.data_byte);
                    m = fresh_mode;
                end
            endcase
        end
        if (item.data_byte == CH_NUL || item.is_last)
        begin
            if (m == MODE_IDENT)
                b = push(b, EV_ABANDON, TK_IDENT, CH_NUL);
            else if (m == MODE_STRING || m == MODE_ESCAPE)
                b = push(b, EV_ABANDON, TK_STRING, CH_NUL);
            b = push(b, EV_EOF, TK_EOF, CH_NUL);
            m = MODE_SKIP;
        end
        last_idx = b.count - CountWidth'(1);
        if (b.count != '0)
            b.ev[last_idx[PtrWidth-1:0]].last_of_run = 1'b1;
        batch = b;
        mode_next = m;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            mode_reg <= MODE_SKIP;
        else if (accept)
            mode_reg <= mode_next;
    end

endmodule

FILE: rtl/core/ctt_outq.sv
module ctt_outq (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                load,
    input  ctt_pkg::ctt_batch_t batch,
    output logic                room,
    output logic                event_valid,
    input  logic                event_stall,
    output ctt_pkg::ctt_out_t   event_item
);
    import ctt_pkg::*;

    ctt_out_t [MaxEvents-1:0] entry_reg;
    logic [CountWidth-1:0]    cnt_reg;
    logic [PtrWidth-1:0]      rd_reg;
    logic                     pop;

    assign event_valid = (cnt_reg != '0);
    assign pop = event_valid && !event_stall;
    assign room = (cnt_reg == '0) || (cnt_reg == CountWidth'(1) && pop);
    assign event_item = entry_reg[rd_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
            rd_reg  <= '0;
        end
        else if (load)
        begin
            cnt_reg <= batch.count;
            rd_reg  <= '0;
        end
        else if (pop)
        begin
            cnt_reg <= cnt_reg - CountWidth'(1);
            rd_reg  <= rd_reg + PtrWidth'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
            entry_reg <= batch.ev;
    end

endmodule

FILE: rtl/core/config_text_tokenizer.sv
// channel   dir  handshake                 payload
// byte      in   byte_valid / byte_stall   ctt_in_t  {data_byte, is_last}
// event     out  event_valid / event_stall ctt_out_t {event_kind, token_kind,
//                                                     char_out, last_of_run}
//
// One byte is scanned per cycle while byte_stall is low; its zero to four events land in a
// four-entry event buffer and leave one per cycle while event_stall is low.
// byte_stall is high while the buffer still holds events beyond the one leaving now.
// Reset puts the scanner in skip mode and empties the buffer.
module config_text_tokenizer (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              byte_valid,
    output logic              byte_stall,
    input  ctt_pkg::ctt_in_t  byte_item,
    output logic              event_valid,
    input  logic              event_stall,
    output ctt_pkg::ctt_out_t event_item
);
    import ctt_pkg::*;

    ctt_batch_t batch;
    logic       room;
    logic       accept;

    assign byte_stall = !room;
    assign accept = byte_valid && room;

    ctt_scan u_scan (
        .clk    (clk),
        .rst_n  (rst_n),
        .accept (accept),
        .item   (byte_item),
        .batch  (batch)
    );

    ctt_outq u_outq (
        .clk         (clk),
        .rst_n       (rst_n),
        .load        (accept),
        .batch       (batch),
        .room        (room),
        .event_valid (event_valid),
        .event_stall (event_stall),
        .event_item  (event_item)
    );

endmodule

FILE: verif/config_text_tokenizer_tb.sv
`timescale 1ns / 100ps

module config_text_tokenizer_tb;

    import ctt_pkg::*;

    localparam int CycleLimit = 200000;
    localparam int RandomBytes = 270;
    localparam int CalmFrom = 235;
    localparam int DrainCycles = 12;
    localparam int ReportLimit = 10;

    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] PUNCT_CHARS [0:7] = '{CH_LPAREN, CH_RPAREN, CH_LBRACE, CH_RBRACE,
                                                 CH_LBRACK, CH_RBRACK, CH_HYPHEN, CH_COMMA};

    typedef enum logic [2:0] {
        SCAN_SKIP,
        SCAN_SLASH,
        SCAN_COMMENT,
        SCAN_IDENT,
        SCAN_STRING,
        SCAN_ESCAPE
    } scan_mode_t;

    typedef struct {
        ctt_in_t item;
        bit      hold;
        bit      calm;
    } byte_entry_t;

    logic     clk;
    logic     rst_n = 1'b0;
    logic     byte_valid = 1'b0;
    logic     byte_stall;
    ctt_in_t  byte_item = '0;
    logic     event_valid;
    logic     event_stall = 1'b0;
    ctt_out_t event_item;

    byte_entry_t byte_queue[$];
    ctt_out_t    expected_events[$];
    ctt_out_t    step_events[$];
    scan_mode_t  scan_mode = SCAN_SKIP;

    bit  hold_next = 1'b0;
    bit  calm_now = 1'b0;
    int  stim_count = 0;
    logic pending_results = 1'b0;
    logic quiet_phase = 1'b0;
    int  cycle_count = 0;
    int  send_gap = 0;
    int  stall_left = 0;
    int  bytes_accepted = 0;
    int  events_checked = 0;
    int  mismatch_count = 0;

    config_text_tokenizer dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .byte_valid  (byte_valid),
        .byte_stall  (byte_stall),
        .byte_item   (byte_item),
        .event_valid (event_valid),
        .event_stall (event_stall),
        .event_item  (event_item)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
    end

    // ---------------- predictor ----------------

    function automatic bit is_letter(logic [7:0] b);
        return (b >= CH_UPPER_A && b <= CH_UPPER_Z) || (b >= CH_LOWER_A && b <= CH_LOWER_Z);
    endfunction

    function automatic void add_event(logic [2:0] ev, logic [3:0] tk, logic [7:0] ch);
        ctt_out_t e;
        e.event_kind = ev;
        e.token_kind = tk;
        e.char_out = ch;
        e.last_of_run = 1'b0;
        if (step_events.size() < MaxEvents)
            step_events.push_back(e);
    endfunction

    function automatic void scan_fresh(logic [7:0] b);
        logic [3:0] tk;
        bit single;
        single = 1'b1;
        case (b)
            CH_LPAREN: tk = TK_LPAREN;
            CH_RPAREN: tk = TK_RPAREN;
            CH_LBRACE: tk = TK_LBRACE;
            CH_RBRACE: tk = TK_RBRACE;
            CH_LBRACK: tk = TK_LBRACK;
            CH_RBRACK: tk = TK_RBRACK;
            CH_HYPHEN: tk = TK_HYPHEN;
            CH_COMMA:  tk = TK_COMMA;
            default:
            begin
                single = 1'b0;
                tk = TK_EOF;
            end
        endcase
        scan_mode = SCAN_SKIP;
        if (is_letter(b))
        begin
            add_event(EV_BEGIN, TK_IDENT, CH_NUL);
            add_event(EV_CONTENT, TK_IDENT, b);
            scan_mode = SCAN_IDENT;
        end
        else if (b == CH_QUOTE)
        begin
            add_event(EV_BEGIN, TK_STRING, CH_NUL);
            scan_mode = SCAN_STRING;
        end
        else if (single)
        begin
            add_event(EV_BEGIN, tk, CH_NUL);
            add_event(EV_END, tk, CH_NUL);
        end
        else if (b == CH_SLASH)
            scan_mode = SCAN_SLASH;
    endfunction

    function automatic void scan_char(logic [7:0] b);
        case (scan_mode)
            SCAN_SLASH:
                if (b == CH_SLASH)
                    scan_mode = SCAN_COMMENT;
                else
                    scan_fresh(b);
            SCAN_COMMENT:
                if (b == CH_NEWLINE)
                    scan_mode = SCAN_SKIP;
            SCAN_IDENT:
                if (is_letter(b))
                    add_event(EV_CONTENT, TK_IDENT, b);
                else
                begin
                    add_event(EV_END, TK_IDENT, CH_NUL);
                    scan_fresh(b);
                end
            SCAN_STRING:
                if (b == CH_BSLASH)
                    scan_mode = SCAN_ESCAPE;
                else if (b == CH_QUOTE)
                begin
                    add_event(EV_END, TK_STRING, CH_NUL);
                    scan_mode = SCAN_SKIP;
                end
                else
                    add_event(EV_CONTENT, TK_STRING, b);
            SCAN_ESCAPE:
            begin
                add_event(EV_CONTENT, TK_STRING, b);
                scan_mode = SCAN_STRING;
            end
            default:
                scan_fresh(b);
        endcase
    endfunction

    function automatic void end_of_text();
        if (scan_mode == SCAN_IDENT)
            add_event(EV_ABANDON, TK_IDENT, CH_NUL);
        else if (scan_mode == SCAN_STRING || scan_mode == SCAN_ESCAPE)
            add_event(EV_ABANDON, TK_STRING, CH_NUL);
        add_event(EV_EOF, TK_EOF, CH_NUL);
        scan_mode = SCAN_SKIP;
    endfunction

    function automatic void predict_events(ctt_in_t text_item);
        step_events.delete();
        if (text_item.data_byte == CH_NUL)
            end_of_text();
        else
        begin
            scan_char(text_item.data_byte);
            if (text_item.is_last)
                end_of_text();
        end
        if (step_events.size() != 0)
            step_events[step_events.size() - 1].last_of_run = 1'b1;
        foreach (step_events[i])
            expected_events.push_back(step_events[i]);
    endfunction

    function automatic void check_event(ctt_out_t got);
        ctt_out_t want;
        events_checked++;
        if (expected_events.size() == 0)
        begin
            mismatch_count++;
            if (mismatch_count <= ReportLimit)
                $display("unexpected event: ev=%0d tok=%0d ch=%02h last=%0b",
                         got.event_kind, got.token_kind, got.char_out, got.last_of_run);
            return;
        end
        want = expected_events.pop_front();
        if (got.event_kind !== want.event_kind || got.token_kind !== want.token_kind ||
            got.char_out !== want.char_out || got.last_of_run !== want.last_of_run)
        begin
            mismatch_count++;
            if (mismatch_count <= ReportLimit)
                $display({"event mismatch: expected ev=%0d tok=%0d ch=%02h last=%0b, ",
                          "got ev=%0d tok=%0d ch=%02h last=%0b"},
                         want.event_kind, want.token_kind, want.char_out, want.last_of_run,
                         got.event_kind, got.token_kind, got.char_out, got.last_of_run);
        end
    endfunction

    // ---------------- stimulus ----------------

    function automatic void queue_byte(logic [7:0] b, bit last = 1'b0, bit counted = 1'b1);
        byte_entry_t e;
        e.item.data_byte = b;
        e.item.is_last = last;
        e.hold = hold_next;
        e.calm = calm_now;
        hold_next = 1'b0;
        byte_queue.push_back(e);
        if (counted)
            stim_count++;
    endfunction

    function automatic void queue_text(string s);
        for (int i = 0; i < s.len(); i++)
            queue_byte(s[i]);
    endfunction

    function automatic void mark_last();
        byte_queue[byte_queue.size() - 1].item.is_last = 1'b1;
    endfunction

    function automatic logic [7:0] pick_letter();
        logic [7:0] c;
        c = 8'($urandom_range(0, 25));
        return ($urandom_range(0, 1) ? CH_UPPER_A : CH_LOWER_A) + c;
    endfunction

    function automatic logic [7:0] pick_nonzero();
        return 8'($urandom_range(1, 255));
    endfunction

    function automatic void queue_random_text();
        int n_tokens;
        int len;
        logic [7:0] c;
        n_tokens = $urandom_range(1, 8);
        for (int t = 0; t < n_tokens; t++)
        begin
            case ($urandom_range(0, 9))
                0, 1:
                    queue_byte(PUNCT_CHARS[$urandom_range(0, 7)]);
                2, 3:
                begin
                    len = $urandom_range(0, 7) == 0 ? $urandom_range(7, 12) : $urandom_range(1, 6);
                    for (int i = 0; i < len; i++)
                        queue_byte(pick_letter());
                end
                4, 5:
                begin
                    queue_byte(CH_QUOTE);
                    len = $urandom_range(0, 5);
                    for (int i = 0; i < len; i++)
                    begin
                        if ($urandom_range(0, 5) == 0)
                        begin
                            queue_byte(CH_BSLASH);
                            queue_byte(pick_nonzero());
                        end
                        else
                        begin
                            c = pick_nonzero();
                            if (c == CH_QUOTE || c == CH_BSLASH)
                                c = CH_LOWER_A;
                            queue_byte(c);
                        end
                    end
                    // occasionally leave the string open
                    if ($urandom_range(0, 7) != 0)
                        queue_byte(CH_QUOTE);
                end
                6:
                begin
                    queue_byte(CH_SLASH);
                    queue_byte(CH_SLASH);
                    len = $urandom_range(0, 4);
                    for (int i = 0; i < len; i++)
                    begin
                        c = pick_nonzero();
                        if (c == CH_NEWLINE)
                            c = CH_SLASH;
                        queue_byte(c);
                    end
                    queue_byte(CH_NEWLINE);
                end
                7:
                    queue_byte(CH_SLASH);
                8:
                    queue_byte(pick_nonzero());
                default:
                    case ($urandom_range(0, 2))
                        0: queue_byte(CH_SPACE, 1'b0, 1'b0);
                        1: queue_byte(CH_TAB, 1'b0, 1'b0);
                        default: queue_byte(CH_NEWLINE, 1'b0, 1'b0);
                    endcase
            endcase
        end
        case ($urandom_range(0, 3))
            0: queue_byte(CH_NUL, 1'($urandom_range(0, 1)));
            1, 2: mark_last();
            default: ;
        endcase
    endfunction

    // ---------------- driver ----------------

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            byte_valid <= 1'b0;
            byte_item <= '0;
        end
        else if (!byte_valid || !byte_stall)
        begin
            if (send_gap > 0)
            begin
                byte_valid <= 1'b0;
                send_gap--;
            end
            else if (byte_queue.size() != 0 &&
                     (!byte_queue[0].hold || (!byte_valid && !pending_results)))
            begin
                byte_valid <= 1'b1;
                byte_item <= byte_queue[0].item;
                if (byte_queue[0].calm)
                    quiet_phase <= 1'b1;
                else if (!cycle_count[6] && $urandom_range(0, 4) == 0)
                    send_gap = $urandom_range(1, 3);
                void'(byte_queue.pop_front());
            end
            else
                byte_valid <= 1'b0;
        end
    end

    // ---------------- monitor ----------------

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (byte_valid && !byte_stall)
            begin
                bytes_accepted++;
                predict_events(byte_item);
            end
            if (event_valid && !event_stall)
                check_event(event_item);
            pending_results <= (expected_events.size() != 0);

            if (stall_left > 0)
            begin
                event_stall <= 1'b1;
                stall_left--;
            end
            else if (!quiet_phase && !cycle_count[6] && $urandom_range(0, 5) == 0)
            begin
                event_stall <= 1'b1;
                stall_left = $urandom_range(0, 2);
            end
            else
                event_stall <= 1'b0;
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CycleLimit)
        begin
            $display("timeout after %0d cycles, %0d events outstanding",
                     cycle_count, expected_events.size());
            $display("status: fail");
            $finish;
        end
    end

    // ---------------- sequence ----------------

    initial
    begin
        // single-character tokens
        queue_text("(){}[]-,");
        // identifier closed by a punctuation token, which is rescanned
        queue_text("Az(");
        // string with an escaped quote
        queue_text("\"\\\"q\"");
        // comment, then lone slash followed by a letter, then a high byte ends it
        queue_text("//z\n/a");
        queue_byte(8'hFF);
        // zero byte abandons an identifier
        queue_text("b");
        queue_byte(CH_NUL);
        // last byte closes an identifier and adds a token: four events
        queue_text("x]");
        mark_last();
        // open string at end of text
        queue_text("\"w");
        mark_last();

        hold_next = 1'b1;
        stim_count = 0;
        while (stim_count < RandomBytes)
        begin
            if ($urandom_range(0, 9) == 0)
                hold_next = 1'b1;
            calm_now = (stim_count >= CalmFrom);
            queue_random_text();
        end
        queue_byte(CH_NUL);

        while (byte_queue.size() != 0 || byte_valid)
            @(posedge clk);
        while (expected_events.size() != 0)
            @(posedge clk);
        repeat (DrainCycles) @(posedge clk);

        $display("covered %0d text bytes and %0d token events, with stalls on both sides",
                 bytes_accepted, events_checked);
        if (mismatch_count == 0 && expected_events.size() == 0)
            $display("status: pass");
        else
        begin
            $display("%0d mismatches", mismatch_count);
            $display("status: fail");
        end
        $finish;
    end

endmodule
